// ===== src/drr_pkg.sv =====
package drr_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned RouteDepthDef = 256;
  localparam int unsigned DelayBitsDef  = 32;

  // Item kinds carried on the input tuser
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_REC    = 2'd2;
  localparam logic [1:0] FUNC_PLAY   = 2'd3;

  // Operating modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_REC  = 2'd1;
  localparam logic [1:0] MODE_PLAY = 2'd2;

  localparam int unsigned FuncW     = 2;
  localparam int unsigned EntriesW  = 9;
  localparam int unsigned PayloadW  = 32;
  localparam int unsigned STdataW   = 32;
  localparam int unsigned MTdataW   = 48;

  // One drive command; throttle sits in the lowest bits
  typedef struct packed {
    logic signed [7:0] steering;
    logic signed [7:0] direction;
    logic [15:0]       throttle;
  } drive_t;

  typedef struct packed {
    logic [1:0] func;
    drive_t     drive;
  } item_t;

  typedef struct packed {
    logic                drive_valid;
    drive_t              drive;
    logic                replay_end;
    logic                is_recording;
    logic                is_replaying;
    logic [EntriesW-1:0] entries_stored;
  } result_t;

endpackage

// ===== src/drr_ram.sv =====
module drr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/drr_core.sv =====
module drr_core #(
  parameter int unsigned RouteDepth = drr_pkg::RouteDepthDef,
  parameter int unsigned DelayBits  = drr_pkg::DelayBitsDef,
  localparam int unsigned Aw        = $clog2(RouteDepth),
  localparam int unsigned Cw        = $clog2(RouteDepth + 1),
  localparam int unsigned MemW      = drr_pkg::PayloadW + DelayBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  drr_pkg::item_t   item_i,
  input  logic [MemW-1:0]  rd_data_i,
  output logic             mem_we_o,
  output logic [Aw-1:0]    mem_waddr_o,
  output logic [MemW-1:0]  mem_wdata_o,
  output logic             mem_re_o,
  output logic [Aw-1:0]    mem_raddr_o,
  output drr_pkg::result_t result_o
);

  import drr_pkg::*;

  logic [1:0]           mode_q, mode_d;
  logic [Cw-1:0]        count_q, count_d;
  logic [DelayBits-1:0] elapsed_q, elapsed_d;
  logic [Cw-1:0]        cursor_q, cursor_d;
  logic [DelayBits-1:0] countdown_q, countdown_d;
  drive_t               cur_q, cur_d;      // entry at the cursor
  drive_t               last_q, last_d;    // last stored command
  logic [MemW-1:0]      first_q, first_d;  // entry 0, kept for replay start
  logic [Cw-1:0]        cursor_inc;
  logic [MemW-1:0]      new_entry;
  drive_t               rd_drive;
  logic [DelayBits-1:0] rd_delay;

  assign cursor_inc = cursor_q + Cw'(1);
  assign new_entry  = {item_i.drive, elapsed_q};
  assign rd_drive   = rd_data_i[MemW-1:DelayBits];
  assign rd_delay   = rd_data_i[DelayBits-1:0];

  always_comb begin
    mode_d      = mode_q;
    count_d     = count_q;
    elapsed_d   = elapsed_q;
    cursor_d    = cursor_q;
    countdown_d = countdown_q;
    cur_d       = cur_q;
    last_d      = last_q;
    first_d     = first_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[Aw-1:0];
    mem_wdata_o = new_entry;
    mem_re_o    = 1'b0;
    mem_raddr_o = Aw'(cursor_q + Cw'(2));
    result_o    = '0;

    if (item_valid_i) begin
      unique case (item_i.func)
        FUNC_SAMPLE: begin
          if (mode_q == MODE_REC) begin
            if (count_q == Cw'(RouteDepth)) begin
              mode_d = MODE_IDLE;
            end else if (!(count_q != '0 && last_q == item_i.drive)) begin
              mem_we_o  = 1'b1;
              last_d    = item_i.drive;
              elapsed_d = '0;
              count_d   = count_q + Cw'(1);
              if (count_q == '0) begin
                first_d = new_entry;
              end
            end
          end
        end
        FUNC_TICK: begin
          if (mode_q == MODE_REC) begin
            if (elapsed_q != '1) begin
              elapsed_d = elapsed_q + DelayBits'(1);
            end
          end else if (mode_q == MODE_PLAY) begin
            if (countdown_q > DelayBits'(1)) begin
              countdown_d = countdown_q - DelayBits'(1);
            end else begin
              result_o.drive_valid = 1'b1;
              result_o.drive       = cur_q;
              if (cursor_inc >= count_q) begin
                result_o.replay_end = 1'b1;
                mode_d      = MODE_IDLE;
                cursor_d    = '0;
                countdown_d = '0;
              end else begin
                // advance: the prefetched entry becomes current, fetch the one after
                cursor_d    = cursor_inc;
                cur_d       = rd_drive;
                countdown_d = rd_delay;
                mem_re_o    = 1'b1;
              end
            end
          end
        end
        FUNC_REC: begin
          if (mode_q == MODE_REC) begin
            mode_d = MODE_IDLE;
          end else if (mode_q == MODE_IDLE) begin
            mode_d    = MODE_REC;
            count_d   = '0;
            elapsed_d = '0;
          end
        end
        FUNC_PLAY: begin
          if (mode_q == MODE_PLAY) begin
            result_o.replay_end = 1'b1;
            mode_d      = MODE_IDLE;
            cursor_d    = '0;
            countdown_d = '0;
          end else if (mode_q == MODE_IDLE && count_q != '0) begin
            mode_d      = MODE_PLAY;
            cursor_d    = '0;
            cur_d       = first_q[MemW-1:DelayBits];
            countdown_d = first_q[DelayBits-1:0];
            mem_re_o    = 1'b1;
            mem_raddr_o = Aw'(1);
          end
        end
        default: ;
      endcase
      result_o.is_recording   = (mode_d == MODE_REC);
      result_o.is_replaying   = (mode_d == MODE_PLAY);
      result_o.entries_stored = EntriesW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      count_q     <= '0;
      elapsed_q   <= '0;
      cursor_q    <= '0;
      countdown_q <= '0;
    end else begin
      mode_q      <= mode_d;
      count_q     <= count_d;
      elapsed_q   <= elapsed_d;
      cursor_q    <= cursor_d;
      countdown_q <= countdown_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    last_q  <= last_d;
    first_q <= first_d;
  end

endmodule

// ===== src/drive_route_record_replay.sv =====
// Channel  Dir  Transfer     Fields (lowest bit first)
// s_axis   in   one item     tuser: func[1:0]
//                            tdata: throttle_in[15:0], direction_in[23:16], steering_in[31:24]
// m_axis   out  one result   tdata: drive_valid[0], throttle_out[16:1], direction_out[24:17],
//                            steering_out[32:25], replay_end[33], is_recording[34],
//                            is_replaying[35], entries_stored[44:36], zero[47:45]
//
// Every input transfer yields exactly one result transfer.
// One item per cycle unless a stalled output holds the input off: state is updated at the
// input transfer and the result is held in an output register; the route store is read
// ahead so its registered read port is always one entry in front of the replay cursor.
// Reset (rst_ni low, asynchronous) returns to idle with an empty store.
// A stalled output only holds the input off once the output register is full.
module drive_route_record_replay #(
  parameter int unsigned RouteDepth = drr_pkg::RouteDepthDef,
  parameter int unsigned DelayBits  = drr_pkg::DelayBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [drr_pkg::STdataW-1:0]  s_axis_tdata,  // throttle, direction, steering
  input  logic [drr_pkg::FuncW-1:0]    s_axis_tuser,  // func
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [drr_pkg::MTdataW-1:0]  m_axis_tdata   // see table above
);

  import drr_pkg::*;

  localparam int unsigned Aw   = $clog2(RouteDepth);
  localparam int unsigned MemW = PayloadW + DelayBits;

  logic                in_xfer;
  item_t               item;
  result_t             result;
  logic                mem_we;
  logic [Aw-1:0]       mem_waddr;
  logic [MemW-1:0]     mem_wdata;
  logic                mem_re;
  logic [Aw-1:0]       mem_raddr;
  logic [MemW-1:0]     mem_rdata;
  logic                out_valid_q, out_valid_d;
  logic [MTdataW-1:0]  out_data_q, out_data_d;

  // Take a new item whenever the output register is empty or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign item.func  = s_axis_tuser;
  assign item.drive = s_axis_tdata;

  drr_core #(
    .RouteDepth (RouteDepth),
    .DelayBits  (DelayBits)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_xfer),
    .item_i       (item),
    .rd_data_i    (mem_rdata),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .result_o     (result)
  );

  // Route store: one command and its delay per entry, delay in the low bits
  drr_ram #(
    .Width (MemW),
    .Depth (RouteDepth)
  ) u_route_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: load on an input transfer, drop once the result is taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'b000, result.entries_stored, result.is_replaying,
                     result.is_recording, result.replay_end, result.drive,
                     result.drive_valid};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== verif/drr_route_checker.sv =====
module drr_route_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [drr_pkg::STdataW-1:0] s_axis_tdata,   // throttle[15:0], direction[23:16],
                                                      // steering[31:24]
  input  logic [drr_pkg::FuncW-1:0]   s_axis_tuser,   // func[1:0]
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [drr_pkg::MTdataW-1:0] m_axis_tdata,   // drive_valid, throttle, direction,
                                                      // steering, replay_end, is_recording,
                                                      // is_replaying, entries_stored, zero pad
  output int                          fail_count_o,
  output int                          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import drr_pkg::*;

  localparam int unsigned Depth  = RouteDepthDef;
  localparam int unsigned DelayW = DelayBitsDef;

  typedef struct packed {
    drive_t              cmd;
    logic [DelayW-1:0]   delay;
  } route_entry_t;

  route_entry_t        route_mem [Depth];
  logic [1:0]          cur_mode   = MODE_IDLE;
  logic [EntriesW-1:0] fill_level = '0;
  logic [DelayW-1:0]   tick_count = '0;
  int unsigned         play_idx   = 0;
  logic [DelayW-1:0]   play_wait  = '0;

  result_t expected_results [$];
  int      fails = 0;
  int      depth_now = 0;

  assign fail_count_o = fails;
  assign pending_o    = depth_now;

  // Advance the route state by one item and return the result it produces.
  function automatic result_t predict_route(input item_t it);
    result_t r;
    r = '0;
    case (it.func)
      FUNC_SAMPLE: begin
        if (cur_mode == MODE_REC) begin
          if (fill_level >= Depth) begin
            cur_mode = MODE_IDLE;
          end else if (!(fill_level > 0 && route_mem[fill_level - 1].cmd == it.drive)) begin
            route_mem[fill_level] = '{cmd: it.drive, delay: tick_count};
            tick_count = '0;
            fill_level++;
          end
        end
      end
      FUNC_TICK: begin
        if (cur_mode == MODE_REC) begin
          if (tick_count != '1) tick_count++;
        end else if (cur_mode == MODE_PLAY) begin
          if (play_wait > 1) begin
            play_wait--;
          end else begin
            r.drive_valid = 1'b1;
            r.drive       = route_mem[play_idx].cmd;
            play_idx++;
            if (play_idx >= fill_level) begin
              r.replay_end = 1'b1;
              cur_mode     = MODE_IDLE;
              play_idx     = 0;
              play_wait    = '0;
            end else begin
              play_wait = route_mem[play_idx].delay;
            end
          end
        end
      end
      FUNC_REC: begin
        if (cur_mode == MODE_REC) begin
          cur_mode = MODE_IDLE;
        end else if (cur_mode == MODE_IDLE) begin
          cur_mode   = MODE_REC;
          fill_level = '0;
          tick_count = '0;
        end
      end
      FUNC_PLAY: begin
        if (cur_mode == MODE_PLAY) begin
          r.replay_end = 1'b1;
          cur_mode     = MODE_IDLE;
          play_idx     = 0;
          play_wait    = '0;
        end else if (cur_mode == MODE_IDLE && fill_level > 0) begin
          cur_mode  = MODE_PLAY;
          play_idx  = 0;
          play_wait = route_mem[0].delay;
        end
      end
    endcase
    r.is_recording   = (cur_mode == MODE_REC);
    r.is_replaying   = (cur_mode == MODE_PLAY);
    r.entries_stored = fill_level;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    result_t got;
    item_t   it;
    if (!rst_ni) begin
      cur_mode   = MODE_IDLE;
      fill_level = '0;
      tick_count = '0;
      play_idx   = 0;
      play_wait  = '0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expectation waiting: 0x%0h", m_axis_tdata);
          fails++;
        end else begin
          want = expected_results.pop_front();
          got.drive_valid     = m_axis_tdata[0];
          got.drive.throttle  = m_axis_tdata[16:1];
          got.drive.direction = m_axis_tdata[24:17];
          got.drive.steering  = m_axis_tdata[32:25];
          got.replay_end      = m_axis_tdata[33];
          got.is_recording    = m_axis_tdata[34];
          got.is_replaying    = m_axis_tdata[35];
          got.entries_stored  = m_axis_tdata[44:36];
          check_field("drive_valid", 16'(want.drive_valid), 16'(got.drive_valid));
          check_field("throttle_out", want.drive.throttle, got.drive.throttle);
          check_field("direction_out", 16'(want.drive.direction[7:0]),
                      16'(got.drive.direction[7:0]));
          check_field("steering_out", 16'(want.drive.steering[7:0]),
                      16'(got.drive.steering[7:0]));
          check_field("replay_end", 16'(want.replay_end), 16'(got.replay_end));
          check_field("is_recording", 16'(want.is_recording), 16'(got.is_recording));
          check_field("is_replaying", 16'(want.is_replaying), 16'(got.is_replaying));
          check_field("entries_stored", 16'(want.entries_stored), 16'(got.entries_stored));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.func  = s_axis_tuser;
        it.drive = s_axis_tdata;
        expected_results.push_back(predict_route(it));
      end
    end
    depth_now = expected_results.size();
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import drr_pkg::*;

  localparam int unsigned ItemTarget    = 1700;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 16;

  // Clock and the single reset at the start of the run
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  // Input channel, driven by the stimulus process
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [STdataW-1:0] s_axis_tdata  = '0;   // throttle[15:0], direction[23:16], steering[31:24]
  logic [FuncW-1:0]   s_axis_tuser  = FUNC_SAMPLE;   // func[1:0]

  // Output channel, drained by the receiver process
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [MTdataW-1:0] m_axis_tdata;   // drive_valid[0], throttle[16:1], direction[24:17],
                                      // steering[32:25], replay_end[33], is_recording[34],
                                      // is_replaying[35], entries_stored[44:36], zero[47:45]

  int fail_count;
  int pending;

  // Idling controls for the sender and the receiver, set by the stimulus
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  bit          hold_req           = 1'b0;

  // Counts of items that exercise the block, and hints for the next replay run
  int unsigned items_sent   = 0;
  int unsigned last_entries = 0;
  int unsigned last_ticks   = 0;

  drive_route_record_replay i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  drr_route_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  function automatic drive_t make_drive(input logic [15:0] thr, input logic [7:0] dir,
                                        input logic [7:0] ste);
    drive_t d;
    d.throttle  = thr;
    d.direction = dir;
    d.steering  = ste;
    return d;
  endfunction

  function automatic drive_t rand_drive();
    return make_drive(16'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Offer one item and hold it until the transfer. An optional idle gap comes first,
  // with tvalid low; back-to-back items keep tvalid high across the edge.
  task automatic send_item(input logic [1:0] func, input drive_t drv, input bit counts);
    if (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < sender_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= drv;
    do @(posedge clk_i); while (!s_axis_tready);
    if (counts) items_sent++;
  endtask

  // One recording run: start, a mix of new samples, repeats, ticks and stray replay toggles, then stop.
  // A full run stores a whole route and ends on the sample that overflows the store,
  // which drops back to idle by itself.
  task automatic record_run(input bit full);
    int unsigned steps;
    int unsigned r;
    drive_t      prev;
    steps        = full ? RouteDepthDef : $urandom_range(24, 1);
    last_entries = 0;
    last_ticks   = 0;
    prev         = rand_drive();
    send_item(FUNC_REC, rand_drive(), 1'b1);
    for (int unsigned i = 0; i < steps; i++) begin
      if (full) begin
        // Incrementing throttle keeps every sample distinct from the last stored one
        send_item(FUNC_SAMPLE, make_drive(16'(i), 8'($urandom), 8'($urandom)), 1'b1);
        last_entries++;
        if ($urandom_range(3, 0) == 0) begin
          repeat ($urandom_range(2, 1)) begin
            send_item(FUNC_TICK, rand_drive(), 1'b1);
            last_ticks++;
          end
        end
      end else begin
        r = $urandom_range(99, 0);
        if (r < 45) begin
          prev = rand_drive();
          send_item(FUNC_SAMPLE, prev, 1'b1);
          last_entries++;
        end else if (r < 60) begin
          send_item(FUNC_SAMPLE, prev, 1'b1);
        end else if (r < 95) begin
          repeat ($urandom_range(3, 1)) begin
            send_item(FUNC_TICK, rand_drive(), 1'b1);
            last_ticks++;
          end
        end else begin
          send_item(FUNC_PLAY, rand_drive(), 1'b1);
        end
      end
    end
    if (full) send_item(FUNC_SAMPLE, rand_drive(), 1'b1);
    else send_item(FUNC_REC, rand_drive(), 1'b1);
  endtask

  // One replay run: start, then enough ticks to reach the end of the route, with
  // stray samples in between; now and then stop it part way through.
  task automatic replay_run();
    int unsigned budget;
    int unsigned stop_at;
    budget  = last_entries + last_ticks + $urandom_range(3, 0);
    stop_at = ($urandom_range(3, 0) == 0) ? $urandom_range(budget, 0) : budget + 1;
    send_item(FUNC_PLAY, rand_drive(), 1'b1);
    for (int unsigned i = 0; i < budget; i++) begin
      if (i == stop_at) begin
        send_item(FUNC_PLAY, rand_drive(), 1'b1);
        break;
      end
      if ($urandom_range(9, 0) == 0) send_item(FUNC_SAMPLE, rand_drive(), 1'b0);
      send_item(FUNC_TICK, rand_drive(), 1'b1);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end
  end

  // Watchdog: give up when nothing has moved on either channel for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("drive_route_record_replay regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned round_no;
    int unsigned r;
    bit          hold_done;
    round_no  = 0;
    hold_done = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling
    send_item(FUNC_SAMPLE, rand_drive(), 1'b1);   // sample while idle: ignored
    send_item(FUNC_TICK, rand_drive(), 1'b1);     // tick while idle: nothing
    send_item(FUNC_PLAY, rand_drive(), 1'b1);     // replay with an empty store: ignored
    send_item(FUNC_REC, rand_drive(), 1'b1);      // record start
    send_item(FUNC_SAMPLE, make_drive(16'hFFFF, 8'h80, 8'h7F), 1'b1);   // stored, delay 0
    send_item(FUNC_SAMPLE, make_drive(16'hFFFF, 8'h80, 8'h7F), 1'b1);   // repeat: dropped
    send_item(FUNC_TICK, rand_drive(), 1'b1);
    send_item(FUNC_TICK, rand_drive(), 1'b1);
    send_item(FUNC_PLAY, rand_drive(), 1'b1);     // replay toggle while recording: ignored
    send_item(FUNC_SAMPLE, make_drive(16'h0000, 8'h7F, 8'h80), 1'b1);   // delay 2
    send_item(FUNC_TICK, rand_drive(), 1'b1);
    send_item(FUNC_SAMPLE, make_drive(16'h8000, 8'h00, 8'hFF), 1'b1);   // delay 1
    send_item(FUNC_REC, rand_drive(), 1'b1);      // record stop
    send_item(FUNC_PLAY, rand_drive(), 1'b1);     // replay start
    send_item(FUNC_REC, rand_drive(), 1'b1);      // record toggle while replaying: ignored
    send_item(FUNC_SAMPLE, rand_drive(), 1'b1);   // sample while replaying: ignored
    send_item(FUNC_TICK, rand_drive(), 1'b1);     // zero delay plays on the first tick
    send_item(FUNC_TICK, rand_drive(), 1'b1);
    send_item(FUNC_PLAY, rand_drive(), 1'b1);     // stop replay part way
    send_item(FUNC_PLAY, rand_drive(), 1'b1);     // restart from the first entry
    repeat (4) send_item(FUNC_TICK, rand_drive(), 1'b1);   // play through to the end
    send_item(FUNC_TICK, rand_drive(), 1'b1);     // tick back in idle
    last_entries = 3;
    last_ticks   = 3;

    // Random part: mostly record-then-replay runs, with noise in between
    while (items_sent < ItemTarget) begin
      case (items_sent * 4 / ItemTarget)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
        default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
      endcase
      // Hold the receiver off once while the sender keeps pushing
      if (!hold_done && items_sent >= 200) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      round_no++;
      r = $urandom_range(99, 0);
      if (round_no == 2 || r < 1) begin
        record_run(1'b1);
        replay_run();
      end else if (r < 72) begin
        record_run(1'b0);
        replay_run();
      end else if (r < 87) begin
        replay_run();
      end else begin
        repeat ($urandom_range(4, 1))
          send_item(2'($urandom_range(3, 0)), rand_drive(), 1'b0);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every expected result, then let the pipeline settle
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("drive_route_record_replay regression: pass");
    end else begin
      $display("drive_route_record_replay regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/drr_pkg.sv
src/drr_ram.sv
src/drr_core.sv
src/drive_route_record_replay.sv
verif/drr_route_checker.sv
verif/tb_top.sv
